@@ hw/rtl/wsrx_pkg.sv @@
// Shared types and constants for the WebSocket receive text deframer.
// Used by the top level and the front, queue, back and checker modules; depends on nothing.

package wsrx_pkg;

	localparam int QUEUE_DEPTH = 4;

	localparam logic [3:0] OPCODE_TEXT = 4'b0001;
	localparam logic [6:0] LEN_EXT16  = 7'd126;
	localparam logic [6:0] LEN_EXT64  = 7'd127;

	typedef enum logic [1:0] {
		KIND_DATA   = 2'd0,
		KIND_END    = 2'd1,
		KIND_CLOSE  = 2'd2,
		KIND_REJECT = 2'd3
	} kind_t;

	// One classified result on its way from the front to the back.
	typedef struct packed {
		kind_t      kind;
		logic [7:0] data;
		logic [7:0] key;
		logic       last;
		logic [7:0] header;
	} item_t;

endpackage

@@ hw/rtl/websocket_rx_text_deframer_unit.sv @@
// Top level of the WebSocket receive text deframer.
// Instantiates wsrx_front, wsrx_queue and wsrx_back; depends on wsrx_pkg.

// The block takes one frame byte per cycle. It keeps doing so while results
// wait downstream, until its result queue (QUEUE_DEPTH items) is full; the
// output register holds one more result beyond that. Every byte is classified
// combinationally by the header tracker in the front, so while the queue has
// room the sustained rate is one item per cycle. A result is written into the
// queue at the edge that accepts the byte causing it. It then moves into the
// output register, where the payload is unmasked, once that register is free
// and the result is at the head of the queue. Bytes that cause no result
// (header, key, ignored bytes) only update the tracker.

module websocket_rx_text_deframer_unit #(
	parameter int QUEUE_DEPTH = wsrx_pkg::QUEUE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,  // [7:0] frame_byte
	input  logic [0:0]  s_tuser,  // [0] frame_start
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,  // [7:0] payload_byte, [15:8] reply_header
	output logic [1:0]  m_tuser,  // [1:0] result_kind
	output logic        m_tlast   // last_of_message
);

	logic            q_full;
	logic            q_empty;
	logic            push;
	logic            pop;
	wsrx_pkg::item_t push_item;
	wsrx_pkg::item_t head;
	wsrx_pkg::kind_t result_kind;
	logic [7:0]      payload_byte;
	logic [7:0]      reply_header;

	wsrx_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (s_tvalid),
		.in_ready    (s_tready),
		.frame_byte  (s_tdata),
		.frame_start (s_tuser[0]),
		.q_full      (q_full),
		.push        (push),
		.push_item   (push_item)
	);

	wsrx_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.full      (q_full),
		.pop       (pop),
		.empty     (q_empty),
		.head      (head)
	);

	wsrx_back u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.q_empty         (q_empty),
		.head            (head),
		.pop             (pop),
		.out_valid       (m_tvalid),
		.out_ready       (m_tready),
		.result_kind     (result_kind),
		.payload_byte    (payload_byte),
		.last_of_message (m_tlast),
		.reply_header    (reply_header)
	);

	assign m_tdata = {reply_header, payload_byte};
	assign m_tuser = result_kind;

endmodule

@@ hw/rtl/wsrx_front.sv @@
// Front part of the deframer: tracks the frame header, collects the masking
// key and classifies each byte into a result item. Depends on wsrx_pkg.

module wsrx_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [7:0]          frame_byte,
	input  logic                frame_start,
	input  logic                q_full,
	output logic                push,
	output wsrx_pkg::item_t     push_item
);

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_LEN,
		PH_KEY,
		PH_DATA,
		PH_DONE
	} phase_t;

	phase_t      phase_q;
	logic [7:0]  header_q;
	logic [31:0] key_q;
	logic [1:0]  key_cnt_q;
	logic [6:0]  left_q;
	logic [1:0]  pos_q;

	logic        accept;
	logic        emit;
	logic [6:0]  len;
	logic [6:0]  left_dec;
	logic        bad_len;

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;
	assign len      = frame_byte[6:0];
	assign left_dec = left_q - 7'd1;
	assign bad_len  = !frame_byte[7] || (len == wsrx_pkg::LEN_EXT16) ||
		(len == wsrx_pkg::LEN_EXT64);

	always_comb begin
		emit             = 1'b0;
		push_item.kind   = wsrx_pkg::KIND_DATA;
		push_item.data   = '0;
		push_item.key    = '0;
		push_item.last   = 1'b0;
		push_item.header = frame_start ? frame_byte : header_q;
		if (frame_start) begin
			if (frame_byte[3:0] != wsrx_pkg::OPCODE_TEXT) begin
				emit           = 1'b1;
				push_item.kind = wsrx_pkg::KIND_CLOSE;
			end
		end else begin
			case (phase_q)
				PH_LEN: begin
					if (bad_len) begin
						emit           = 1'b1;
						push_item.kind = wsrx_pkg::KIND_REJECT;
					end
				end
				PH_KEY: begin
					if (key_cnt_q == 2'd3 && left_q == '0) begin
						emit           = 1'b1;
						push_item.kind = wsrx_pkg::KIND_END;
						push_item.last = 1'b1;
					end
				end
				PH_DATA: begin
					emit           = 1'b1;
					push_item.data = frame_byte;
					push_item.key  = key_q[pos_q*8 +: 8];
					push_item.last = (left_dec == '0);
				end
				default: begin
				end
			endcase
		end
	end

	assign push = accept && emit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_IDLE;
			header_q  <= '0;
			key_q     <= '0;
			key_cnt_q <= '0;
			left_q    <= '0;
			pos_q     <= '0;
		end else if (accept) begin
			if (frame_start) begin
				header_q  <= frame_byte;
				key_q     <= '0;
				key_cnt_q <= '0;
				left_q    <= '0;
				pos_q     <= '0;
				phase_q   <= (frame_byte[3:0] != wsrx_pkg::OPCODE_TEXT) ? PH_DONE : PH_LEN;
			end else begin
				case (phase_q)
					PH_LEN: begin
						if (bad_len) begin
							phase_q <= PH_DONE;
						end else begin
							left_q    <= len;
							key_cnt_q <= '0;
							key_q     <= '0;
							phase_q   <= PH_KEY;
						end
					end
					PH_KEY: begin
						key_q[key_cnt_q*8 +: 8] <= frame_byte;
						key_cnt_q <= key_cnt_q + 2'd1;
						if (key_cnt_q == 2'd3) begin
							pos_q   <= '0;
							phase_q <= (left_q == '0) ? PH_DONE : PH_DATA;
						end
					end
					PH_DATA: begin
						pos_q  <= pos_q + 2'd1;
						left_q <= left_dec;
						if (left_dec == '0) begin
							phase_q <= PH_DONE;
						end
					end
					default: begin
					end
				endcase
			end
		end
	end

endmodule

@@ hw/rtl/wsrx_queue.sv @@
// Short register queue that decouples the front from the back.
// Holds classified result items; depends on wsrx_pkg.

module wsrx_queue #(
	parameter int DEPTH = wsrx_pkg::QUEUE_DEPTH
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  wsrx_pkg::item_t push_item,
	output logic            full,
	input  logic            pop,
	output logic            empty,
	output wsrx_pkg::item_t head
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	wsrx_pkg::item_t entries [DEPTH];
	logic [AW-1:0]   wr_ptr_q;
	logic [AW-1:0]   rd_ptr_q;
	logic [CW-1:0]   count_q;
	logic            do_pop;

	assign full   = (count_q == CW'(DEPTH));
	assign empty  = (count_q == '0);
	assign do_pop = pop && !empty;
	assign head   = entries[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entries[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

@@ hw/rtl/wsrx_back.sv @@
// Back part of the deframer: unmasks the payload byte and holds the result
// in the output register until it is taken. Depends on wsrx_pkg.

module wsrx_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            q_empty,
	input  wsrx_pkg::item_t head,
	output logic            pop,
	output logic            out_valid,
	input  logic            out_ready,
	output wsrx_pkg::kind_t result_kind,
	output logic [7:0]      payload_byte,
	output logic            last_of_message,
	output logic [7:0]      reply_header
);

	logic valid_q;

	assign pop       = !q_empty && (!valid_q || out_ready);
	assign out_valid = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (!valid_q || out_ready) begin
			valid_q <= !q_empty;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			result_kind     <= head.kind;
			payload_byte    <= head.data ^ head.key;
			last_of_message <= head.last;
			reply_header    <= head.header;
		end
	end

endmodule

@@ hw/rtl/wsrx_checker.sv @@
// Port-level checks on the deframer's result stream, bound to the top level.
// Depends on wsrx_pkg and websocket_rx_text_deframer_unit.

module wsrx_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [15:0] m_tdata,
	input logic [1:0]  m_tuser,
	input logic        m_tlast
);

	// A stalled result must stay on the bus unchanged.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser) &&
		$stable(m_tlast))
		else $error("stalled result changed");

	// Only payload results carry a data byte.
	a_zero_data: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser != wsrx_pkg::KIND_DATA) |-> m_tdata[7:0] == 8'h00)
		else $error("non-payload result with nonzero data byte");

	// Close and reject results never end a message.
	a_no_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && ((m_tuser == wsrx_pkg::KIND_CLOSE) ||
		(m_tuser == wsrx_pkg::KIND_REJECT)) |-> !m_tlast)
		else $error("close or reject result marked last");

	// An empty message end is always marked last.
	a_end_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == wsrx_pkg::KIND_END) |-> m_tlast)
		else $error("empty message end not marked last");

endmodule

bind websocket_rx_text_deframer_unit wsrx_checker u_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.m_tlast  (m_tlast)
);
